// File: rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;
    localparam int CMD_W = 2;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // Request to the shared divider and its reply.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

// File: rtl/rau_divider.sv
// Restoring divider, one quotient bit per cycle, shared by GCD and reduction.
module rau_divider #(
    parameter int W = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rau_pkg::div_ctrl_t  ctrl,
    input  logic [W-1:0]        dividend,
    input  logic [W-1:0]        divisor,
    output rau_pkg::div_stat_t  stat,
    output logic [W-1:0]        quotient,
    output logic [W-1:0]        remainder
);
    import rau_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (ctrl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/rational_arith_unit.sv
// Top level: rational add, subtract, multiply, divide with GCD reduction.
// One request at a time. Cross products are formed one multiply per cycle
// (states ST_MUL0, ST_MUL1, ST_MUL2), then the Euclidean GCD runs on a shared
// restoring divider, and two more divides reduce numerator and denominator. The
// next request is taken the cycle after the result has been handed over; a zero
// raw denominator gives 0/1 with div_error set.
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // {b_den[15], b_num[16], a_den[15], a_num[16]} from high bits down, zero padded
    input  logic [63:0] s_tdata,
    // cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // res_num[33], res_den[31] from low bits up
    output logic [63:0] m_tdata,
    // div_error
    output logic        m_tuser
);
    import rau_pkg::*;

    localparam int OW = OPERAND_WIDTH;
    localparam int DENW = OW - 1;           // operand denominator width
    localparam int PW = 2 * OW + 1;         // magnitude width of raw results
    localparam int DW = PW + 1;             // divider width

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_PREP, ST_GCD, ST_GWAIT,
        ST_RNUM, ST_RNWAIT, ST_RDEN, ST_RDWAIT, ST_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      cmd_reg;
    logic signed [OW-1:0] an_reg, bn_reg;
    logic signed [OW:0]   ad_reg, bd_reg;
    logic signed [PW:0]   p0_reg, p1_reg, d_reg;
    logic [DW-1:0]   x_reg, y_reg, mn_reg, md_reg, g_reg;
    logic            neg_reg, err_reg;
    logic [NUM_OUT_W-1:0] rn_reg;
    logic [DEN_OUT_W-1:0] rd_reg;

    logic signed [OW:0]   mul_a, mul_b;
    logic signed [2*OW+1:0] mul_p;
    logic signed [PW:0]   nsum;

    div_ctrl_t       dctl;
    div_stat_t       dst;
    logic [DW-1:0]   ddvd, ddvs, dquo, drem;

    rau_divider #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .ctrl(dctl), .dividend(ddvd), .divisor(ddvs),
        .stat(dst), .quotient(dquo), .remainder(drem)
    );

    // single shared multiplier
    always_comb
    begin
        mul_a = ad_reg;
        mul_b = bd_reg;
        unique case (state_reg)
            ST_MUL0:
            begin
                mul_a = {an_reg[OW-1], an_reg};
                mul_b = (cmd_t'(cmd_reg) == CMD_MUL) ? {bn_reg[OW-1], bn_reg} : bd_reg;
            end
            ST_MUL1:
            begin
                mul_a = {bn_reg[OW-1], bn_reg};
                mul_b = ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = (cmd_t'(cmd_reg) == CMD_DIV) ? {bn_reg[OW-1], bn_reg} : bd_reg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        unique case (cmd_t'(cmd_reg))
            CMD_ADD: nsum = p0_reg + p1_reg;
            CMD_SUB: nsum = p0_reg - p1_reg;
            default: nsum = p0_reg;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {rd_reg, rn_reg};
    assign m_tuser  = err_reg;

    always_comb
    begin
        dctl.start = 1'b0;
        ddvd = x_reg;
        ddvs = y_reg;
        unique case (state_reg)
            ST_GCD:
            begin
                // larger value modulo the smaller one; no step once either is zero
                dctl.start = (x_reg != '0) && (y_reg != '0);
                ddvd = (x_reg > y_reg) ? x_reg : y_reg;
                ddvs = (x_reg > y_reg) ? y_reg : x_reg;
            end
            ST_RNUM:
            begin
                dctl.start = 1'b1;
                ddvd = mn_reg;
                ddvs = g_reg;
            end
            ST_RDEN:
            begin
                dctl.start = 1'b1;
                ddvd = md_reg;
                ddvs = g_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_PREP;
            ST_PREP:   state_next = (d_reg == '0) ? ST_OUT : ST_GCD;
            ST_GCD:
            begin
                if (x_reg == '0 || y_reg == '0) state_next = ST_RNUM;
                else state_next = ST_GWAIT;
            end
            ST_GWAIT:  if (dst.done) state_next = ST_GCD;
            ST_RNUM:   state_next = ST_RNWAIT;
            ST_RNWAIT: if (dst.done) state_next = ST_RDEN;
            ST_RDEN:   state_next = ST_RDWAIT;
            ST_RDWAIT: if (dst.done) state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State and payload; in the GCD loop x keeps the smaller value and y takes
    // the remainder of the larger one by it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '0;
            an_reg    <= '0;
            ad_reg    <= '0;
            bn_reg    <= '0;
            bd_reg    <= '0;
            p0_reg    <= '0;
            p1_reg    <= '0;
            d_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            mn_reg    <= '0;
            md_reg    <= '0;
            g_reg     <= '0;
            neg_reg   <= 1'b0;
            err_reg   <= 1'b0;
            rn_reg    <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cmd_reg <= s_tuser;
                    an_reg  <= OW'(s_tdata[15:0]);
                    ad_reg  <= {2'b00, DENW'(s_tdata[30:16])};
                    bn_reg  <= OW'(s_tdata[46:31]);
                    bd_reg  <= {2'b00, DENW'(s_tdata[61:47])};
                end
                ST_MUL0: p0_reg <= mul_p[PW:0];
                ST_MUL1: p1_reg <= mul_p[PW:0];
                ST_MUL2:
                begin
                    d_reg  <= mul_p[PW:0];
                    p0_reg <= nsum;
                end
                ST_PREP:
                begin
                    neg_reg <= p0_reg[PW] ^ d_reg[PW];
                    mn_reg  <= p0_reg[PW] ? DW'(-p0_reg) : DW'(p0_reg);
                    md_reg  <= d_reg[PW] ? DW'(-d_reg) : DW'(d_reg);
                    x_reg   <= p0_reg[PW] ? DW'(-p0_reg) : DW'(p0_reg);
                    y_reg   <= d_reg[PW] ? DW'(-d_reg) : DW'(d_reg);
                    err_reg <= (d_reg == '0);
                    rn_reg  <= '0;
                    rd_reg  <= DEN_OUT_W'(1);
                end
                ST_GCD:
                begin
                    g_reg <= (x_reg != '0) ? x_reg : y_reg;
                    if (x_reg > y_reg)
                    begin
                        x_reg <= y_reg;
                        y_reg <= x_reg;
                    end
                end
                ST_GWAIT:
                    if (dst.done)
                        y_reg <= drem;
                ST_RNWAIT:
                    if (dst.done)
                    begin
                        rn_reg <= neg_reg ? -NUM_OUT_W'(dquo) : NUM_OUT_W'(dquo);
                        mn_reg <= dquo;
                    end
                ST_RDWAIT:
                    if (dst.done)
                        rd_reg <= (mn_reg == '0) ? DEN_OUT_W'(1) : DEN_OUT_W'(dquo);
                default: ;
            endcase
        end
    end

endmodule

// File: sim/tb.sv
// Testbench for rational_arith_unit: random and directed rational operations, scoreboard check.
class rational_scoreboard;
    typedef struct {
        logic [32:0] num;
        logic [30:0] den;
        logic        err;
    } quotient_t;

    quotient_t pending[$];
    int        errors;
    int        checked;

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        while (x != 0 && y != 0)
        begin
            if (x > y)
                x = x % y;
            else
                y = y % x;
        end
        return (x != 0) ? x : y;
    endfunction

    function void note_request(rau_pkg::cmd_t op, logic signed [15:0] an, logic [14:0] ad,
                               logic signed [15:0] bn, logic [14:0] bd);
        longint    n;
        longint    d;
        longint    sa;
        longint    sb;
        longint    da;
        longint    db;
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] g;
        bit        neg;
        quotient_t q;
        sa = an;
        sb = bn;
        da = ad;
        db = bd;
        case (op)
            rau_pkg::CMD_ADD:
            begin
                n = sa * db + sb * da;
                d = da * db;
            end
            rau_pkg::CMD_SUB:
            begin
                n = sa * db - sb * da;
                d = da * db;
            end
            rau_pkg::CMD_MUL:
            begin
                n = sa * sb;
                d = da * db;
            end
            default:
            begin
                n = sa * db;
                d = da * sb;
            end
        endcase
        if (d == 0)
        begin
            q.num = 0;
            q.den = 1;
            q.err = 1;
        end
        else
        begin
            neg = (n < 0) != (d < 0);
            mn = (n < 0) ? -n : n;
            md = (d < 0) ? -d : d;
            g = gcd64(mn, md);
            mn = mn / g;
            md = md / g;
            if (mn == 0)
            begin
                md = 1;
                neg = 0;
            end
            q.num = neg ? 33'(-mn) : 33'(mn);
            q.den = md[30:0];
            q.err = 0;
        end
        pending.push_back(q);
    endfunction

    function void check_result(logic [32:0] num, logic [30:0] den, logic err);
        quotient_t q;
        checked++;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result num=%0d den=%0d err=%0b", $time,
                     $signed(num), den, err);
            errors++;
            return;
        end
        q = pending.pop_front();
        if (num !== q.num)
        begin
            $display("%0t: res_num expected %0d got %0d", $time, $signed(q.num), $signed(num));
            errors++;
        end
        if (den !== q.den)
        begin
            $display("%0t: res_den expected %0d got %0d", $time, q.den, den);
            errors++;
        end
        if (err !== q.err)
        begin
            $display("%0t: div_error expected %0b got %0b", $time, q.err, err);
            errors++;
        end
    endfunction
endclass

module tb;
    import rau_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    rational_scoreboard scoreboard;
    int   burst_left;
    int   sent;

    rational_arith_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 clk = ~clk;

    // send one request; valid stays high until it is taken and drops only in a gap
    task automatic send_request(cmd_t op, logic [15:0] an, logic [14:0] ad,
                                logic [15:0] bn, logic [14:0] bd);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b0, bd, bn, ad, an};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scoreboard.note_request(op, an, ad, bn, bd);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_num();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 20)) - 10);
            3: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] rand_den();
        case ($urandom_range(0, 5))
            0: return 15'h7fff;
            1: return 15'd1;
            2: return 15'($urandom_range(1, 12));
            3: return ($urandom_range(0, 9) == 0) ? 15'd0 : 15'd2;
            default: return 15'($urandom);
        endcase
    endfunction

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if ((sent / 50) % 3 == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            scoreboard.check_result(m_tdata[32:0], m_tdata[63:33], m_tuser);
    end

    initial
    begin
        #200000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        cmd_t op;
        scoreboard = new();
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = CMD_ADD;
        burst_left = 0;
        sent = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;

        // directed: extremes, each op, divide by zero, zero result, zero denominators
        send_request(CMD_ADD, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7fff);
        send_request(CMD_SUB, 16'h8000, 15'd1, 16'h7fff, 15'd1);
        send_request(CMD_MUL, 16'h8000, 15'd1, 16'h8000, 15'd1);
        send_request(CMD_DIV, 16'h8000, 15'h7fff, 16'hffff, 15'd1);
        send_request(CMD_DIV, 16'd5, 15'd3, 16'd0, 15'd7);
        send_request(CMD_SUB, 16'd3, 15'd4, 16'd6, 15'd8);
        send_request(CMD_MUL, 16'd0, 15'd9, 16'hfff0, 15'd3);
        send_request(CMD_ADD, 16'd1, 15'd0, 16'd2, 15'd3);
        send_request(CMD_MUL, 16'd1, 15'd5, 16'd2, 15'd0);
        send_request(CMD_DIV, 16'd4, 15'd0, 16'd2, 15'd3);
        send_request(CMD_ADD, 16'd6, 15'd4, 16'd10, 15'd4);
        send_request(CMD_DIV, 16'hfffd, 15'd7, 16'hfffe, 15'd5);
        send_request(CMD_ADD, 16'h7fff, 15'd2, 16'h8000, 15'h7ffe);
        send_request(CMD_SUB, 16'h5555, 15'h2aaa, 16'haaaa, 15'h5555);
        s_tvalid <= 1'b0;

        // hold off until everything is back
        while (scoreboard.pending.size() != 0)
            @(negedge clk);

        repeat (590)
        begin
            op = cmd_t'($urandom_range(0, 3));
            send_request(op, rand_num(), rand_den(), rand_num(), rand_den());
        end
        s_tvalid <= 1'b0;

        while (scoreboard.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        $display("Ran %0d requests over add/sub/mul/div incl. zero operands and extremes;",
                 sent);
        $display("%0d results checked with random bursts and output stalls.",
                 scoreboard.checked);
        if (scoreboard.errors == 0 && scoreboard.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: files.f
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rational_arith_unit.sv
sim/tb.sv
